// ===== rtl/core/mts_pkg.sv =====
// Shared types and constants for the multi-timer scheduler.
`default_nettype none

package mts_pkg;

	localparam int unsigned TIME_W      = 48;
	localparam int unsigned ID_W        = 32;
	localparam int unsigned PERIOD_W    = 32;
	localparam int unsigned COUNT_W     = 32;
	// at most this many timers fire on one tick
	localparam int unsigned MAX_RESULTS = 16;
	localparam int unsigned RES_CNT_W   = $clog2(MAX_RESULTS + 1);

	typedef enum logic [1:0] {
		KIND_TICK    = 2'd0,
		KIND_ADD     = 2'd1,
		KIND_DELETE  = 2'd2,
		KIND_REPLACE = 2'd3
	} kind_t;

	typedef enum logic {
		STATUS_FIRED = 1'b0,
		STATUS_FULL  = 1'b1
	} status_t;

	// command word
	typedef struct packed {
		kind_t                      kind;
		logic [ID_W-1:0]            task_id;
		logic [PERIOD_W-1:0]        period_ms;
		logic signed [COUNT_W-1:0]  repeat_count;
	} cmd_word_t;

	// event word
	typedef struct packed {
		status_t                    status;
		logic [ID_W-1:0]            fired_id;
		logic                       last;
	} evt_word_t;

	// one timer table entry
	typedef struct packed {
		logic [ID_W-1:0]            id;
		logic [TIME_W-1:0]          expiry;
		logic [PERIOD_W-1:0]        period;
		logic signed [COUNT_W-1:0]  remaining;
	} slot_entry_t;

endpackage

`default_nettype wire

// ===== rtl/core/mts_if.sv =====
// Valid/ready channel interfaces for the command and event words.
`default_nettype none

interface mts_cmd_if import mts_pkg::*; ();
	logic      valid;
	logic      ready;
	cmd_word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface mts_evt_if import mts_pkg::*; ();
	logic      valid;
	logic      ready;
	evt_word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/multi_timer_scheduler.sv =====
// Multi-timer scheduler: timer table, scan sequencer and event output register.
//
// A table of SLOTS timers is kept in a single-port-write, registered-read memory
// and walked one slot per clock by a small sequencer that shares one 48-bit
// age subtract and compare. The block takes one command word at a time. A
// delete walks the table once, an add walks it up to the first free slot and a
// replace does both in turn. A tick makes one full pass per firing, up to the
// limit of 16 firings, and ends with a pass that shows no further expiry
// unless that limit is hit, since every firing needs a full pass over the table
// to find the oldest expired entry (ties to the lower slot). Events leave
// through an output register, so a stalled event sink stalls the sequencer
// only when a second event is ready to go. The last flag of an event is set
// once the following pass shows no further expiry or the 16th firing is made,
// so below that limit the final event of a tick goes out one pass after the
// one before it. Time and expiries wrap at 2^48; expired means an age below 2^47.
`default_nettype none

module multi_timer_scheduler import mts_pkg::*; #(
	parameter int unsigned SLOTS = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	mts_cmd_if.sink    cmd,
	mts_evt_if.source  evt
);

	localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int unsigned CW = $clog2(SLOTS + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIRE,
		ST_ADD,
		ST_FLUSH
	} state_t;

	state_t                    state_q;
	logic [SLOTS-1:0]          vld_q;
	logic [TIME_W-1:0]         cur_q;
	logic [CW-1:0]             cnt_q;
	logic                      s1_vld_s1;
	logic [IW-1:0]             s1_idx_s1;
	logic                      tick_mode_q;
	logic                      do_add_q;
	logic [ID_W-1:0]           op_id_q;
	logic [PERIOD_W-1:0]       op_period_q;
	logic signed [COUNT_W-1:0] op_count_q;
	logic                      best_hit_q;
	logic [TIME_W-1:0]         best_age_q;
	logic [IW-1:0]             best_idx_q;
	slot_entry_t               best_q;
	logic [RES_CNT_W-1:0]      res_cnt_q;
	logic                      pend_vld_q;
	status_t                   pend_status_q;
	logic [ID_W-1:0]           pend_id_q;
	logic                      out_vld_q;
	evt_word_t                 out_q;

	// timer table memory
	slot_entry_t               mem [SLOTS];
	slot_entry_t               rd_q;
	logic [IW-1:0]             rd_addr;
	logic                      wr_en;
	logic [IW-1:0]             wr_addr;
	slot_entry_t               wr_data;

	logic                      accept;
	logic                      out_free;
	logic                      out_load;
	logic                      scan_end;
	logic                      cnt_live;
	logic                      s1_live;
	logic [TIME_W-1:0]         age;
	logic                      better;
	logic                      del_hit;
	logic                      add_free;
	logic                      rearm;
	logic                      fire_go;
	logic                      cmd_add_ok;

	assign cmd.ready  = (state_q == ST_IDLE);
	assign accept     = cmd.valid && cmd.ready;
	assign out_free   = !out_vld_q || evt.ready;
	assign evt.valid  = out_vld_q;
	assign evt.data   = out_q;
	assign cmd_add_ok = (cmd.data.period_ms != '0) && (cmd.data.repeat_count != '0);

	// scan address and end of pass
	assign cnt_live = (cnt_q < CW'(SLOTS));
	assign rd_addr  = cnt_live ? cnt_q[IW-1:0] : '0;
	assign scan_end = (state_q == ST_SCAN) && !cnt_live && !s1_vld_s1;

	// shared age unit: evaluates the entry read in the previous cycle
	assign s1_live = s1_vld_s1 && vld_q[s1_idx_s1];
	assign age     = cur_q - rd_q.expiry;
	assign better  = tick_mode_q && s1_live && !age[TIME_W-1]
		&& (!best_hit_q || (age > best_age_q));
	assign del_hit = !tick_mode_q && s1_live && (rd_q.id == op_id_q);

	// add: first free slot, one per cycle
	assign add_free = (state_q == ST_ADD) && !vld_q[cnt_q[IW-1:0]];

	// firing: re-arm on negative or above-one counts
	assign rearm   = (best_q.remaining < 0) || (best_q.remaining > 1);
	assign fire_go = (state_q == ST_FIRE) && (!pend_vld_q || out_free);

	// output register gets a new word this cycle
	assign out_load = (fire_go && pend_vld_q) || ((state_q == ST_FLUSH) && out_free);

	// table write port
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cnt_q[IW-1:0];
		wr_data = '{id: op_id_q,
			expiry: cur_q + TIME_W'(op_period_q),
			period: op_period_q,
			remaining: op_count_q};
		if (fire_go && rearm) begin
			wr_en             = 1'b1;
			wr_addr           = best_idx_q;
			wr_data           = best_q;
			wr_data.expiry    = cur_q + TIME_W'(best_q.period);
			wr_data.remaining = (best_q.remaining > 1) ? best_q.remaining - 1
				: best_q.remaining;
		end else if (add_free) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	// sequencer, valid bits and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			vld_q         <= '0;
			cur_q         <= '0;
			cnt_q         <= '0;
			s1_vld_s1     <= 1'b0;
			s1_idx_s1     <= '0;
			tick_mode_q   <= 1'b0;
			do_add_q      <= 1'b0;
			op_id_q       <= '0;
			op_period_q   <= '0;
			op_count_q    <= '0;
			best_hit_q    <= 1'b0;
			best_age_q    <= '0;
			best_idx_q    <= '0;
			best_q        <= '0;
			res_cnt_q     <= '0;
			pend_vld_q    <= 1'b0;
			pend_status_q <= STATUS_FIRED;
			pend_id_q     <= '0;
			out_vld_q     <= 1'b0;
			out_q         <= '0;
		end else begin
			if (evt.ready && !out_load) begin
				out_vld_q <= 1'b0;
			end

			// scan pipeline runs whenever in SCAN
			s1_vld_s1 <= (state_q == ST_SCAN) && cnt_live;
			s1_idx_s1 <= rd_addr;

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_id_q     <= cmd.data.task_id;
						op_period_q <= cmd.data.period_ms;
						op_count_q  <= cmd.data.repeat_count;
						cnt_q       <= '0;
						best_hit_q  <= 1'b0;
						res_cnt_q   <= '0;
						unique case (cmd.data.kind)
							KIND_TICK: begin
								cur_q       <= cur_q + TIME_W'(1);
								tick_mode_q <= 1'b1;
								state_q     <= ST_SCAN;
							end
							KIND_ADD: begin
								if (cmd_add_ok) begin
									state_q <= ST_ADD;
								end
							end
							KIND_DELETE: begin
								tick_mode_q <= 1'b0;
								do_add_q    <= 1'b0;
								state_q     <= ST_SCAN;
							end
							KIND_REPLACE: begin
								tick_mode_q <= 1'b0;
								do_add_q    <= cmd_add_ok;
								state_q     <= ST_SCAN;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end

				ST_SCAN: begin
					if (cnt_live) begin
						cnt_q <= cnt_q + CW'(1);
					end
					if (better) begin
						best_hit_q <= 1'b1;
						best_age_q <= age;
						best_idx_q <= s1_idx_s1;
						best_q     <= rd_q;
					end
					if (del_hit) begin
						vld_q[s1_idx_s1] <= 1'b0;
					end
					if (scan_end) begin
						cnt_q <= '0;
						if (!tick_mode_q) begin
							state_q <= do_add_q ? ST_ADD : ST_IDLE;
						end else if (best_hit_q) begin
							state_q <= ST_FIRE;
						end else if (pend_vld_q) begin
							state_q <= ST_FLUSH;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end

				ST_FIRE: begin
					if (fire_go) begin
						// previous event is known not to be the last one
						if (pend_vld_q) begin
							out_vld_q <= 1'b1;
							out_q     <= '{status: pend_status_q, fired_id: pend_id_q,
								last: 1'b0};
						end
						pend_vld_q    <= 1'b1;
						pend_status_q <= STATUS_FIRED;
						pend_id_q     <= best_q.id;
						if (!rearm) begin
							vld_q[best_idx_q] <= 1'b0;
						end
						res_cnt_q  <= res_cnt_q + RES_CNT_W'(1);
						best_hit_q <= 1'b0;
						cnt_q      <= '0;
						if (res_cnt_q == RES_CNT_W'(MAX_RESULTS - 1)) begin
							state_q <= ST_FLUSH;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end

				ST_ADD: begin
					if (add_free) begin
						vld_q[cnt_q[IW-1:0]] <= 1'b1;
						state_q              <= ST_IDLE;
					end else if (cnt_q == CW'(SLOTS - 1)) begin
						// table full: report the dropped id
						pend_vld_q    <= 1'b1;
						pend_status_q <= STATUS_FULL;
						pend_id_q     <= op_id_q;
						state_q       <= ST_FLUSH;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end

				ST_FLUSH: begin
					if (out_free) begin
						out_vld_q  <= 1'b1;
						out_q      <= '{status: pend_status_q, fired_id: pend_id_q,
							last: 1'b1};
						pend_vld_q <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the multi-timer scheduler: directed and random command words.
`timescale 1ns / 100ps

module testbench;
	import mts_pkg::*;

	localparam int SLOTS          = 16;
	localparam int RANDOM_ITEMS   = 305;
	localparam int TAIL_ITEMS     = 40;    // no idling over the last stretch of words
	localparam int PRESSURE_AT    = 120;   // accepted words before the long sink hold-off
	localparam int HOLD_CYCLES    = 400;
	localparam int DRAIN_CYCLES   = 500;   // idle wait after the last expected event
	localparam int WATCHDOG_LIMIT = 3000;

	logic clk = 1'b0;
	logic arst_n;

	mts_cmd_if cmd_bus ();
	mts_evt_if evt_bus ();

	multi_timer_scheduler #(.SLOTS(SLOTS)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_bus),
		.evt    (evt_bus)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// stimulus and expected events
	cmd_word_t pending_cmds[$];
	evt_word_t expected_events[$];
	int        total_cmds    = 0;
	int        cmds_accepted = 0;
	int        events_seen   = 0;
	int        error_count   = 0;
	int        send_gap;
	int        stall_left;
	int        hold_left;
	logic      pressure_done;
	int        idle_cycles   = 0;
	evt_word_t want_evt;
	logic      quiet_tail;

	assign quiet_tail = (cmds_accepted + TAIL_ITEMS >= total_cmds);

	// shadow timer table
	bit                        tbl_used   [SLOTS];
	logic [ID_W-1:0]           tbl_id     [SLOTS];
	logic [TIME_W-1:0]         tbl_expiry [SLOTS];
	logic [PERIOD_W-1:0]       tbl_period [SLOTS];
	logic signed [COUNT_W-1:0] tbl_left   [SLOTS];
	logic [TIME_W-1:0]         now_ms = '0;

	task automatic flag_error(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		error_count++;
	endtask

	task automatic push_cmd(input kind_t k, input logic [ID_W-1:0] id,
			input logic [PERIOD_W-1:0] period, input logic signed [COUNT_W-1:0] count);
		cmd_word_t w;
		w.kind         = k;
		w.task_id      = id;
		w.period_ms    = period;
		w.repeat_count = count;
		pending_cmds.insert(pending_cmds.size(), w);
	endtask

	// Update the shadow table for one accepted command word and queue its events.
	function automatic void predict_events(input cmd_word_t w);
		evt_word_t         ev;
		evt_word_t         step_q[$];
		int                best;
		int                free_slot;
		logic [TIME_W-1:0] age;
		logic [TIME_W-1:0] best_age;
		step_q = {};
		ev.last = 1'b0;
		if (w.kind == KIND_TICK) begin
			now_ms = now_ms + 48'd1;
			// fire oldest expiry first, ties to the lower slot
			while (step_q.size() < MAX_RESULTS) begin
				best = -1;
				best_age = '0;
				for (int i = 0; i < SLOTS; i++) begin
					age = now_ms - tbl_expiry[i];
					if (tbl_used[i] && !age[TIME_W-1] && (best < 0 || age > best_age)) begin
						best = i;
						best_age = age;
					end
				end
				if (best < 0)
					break;
				ev.status   = STATUS_FIRED;
				ev.fired_id = tbl_id[best];
				step_q.insert(step_q.size(), ev);
				if (tbl_left[best] < 0 || tbl_left[best] > 1) begin
					if (tbl_left[best] > 1)
						tbl_left[best] = tbl_left[best] - 1;
					tbl_expiry[best] = now_ms + TIME_W'(tbl_period[best]);
				end else
					tbl_used[best] = 1'b0;
			end
		end
		// delete part: drop every slot holding the id
		if (w.kind == KIND_DELETE || w.kind == KIND_REPLACE) begin
			for (int i = 0; i < SLOTS; i++)
				if (tbl_used[i] && tbl_id[i] == w.task_id)
					tbl_used[i] = 1'b0;
		end
		// add part: lowest free slot, or a full flag
		if ((w.kind == KIND_ADD || w.kind == KIND_REPLACE) &&
				w.period_ms != '0 && w.repeat_count != 0) begin
			free_slot = -1;
			for (int i = SLOTS - 1; i >= 0; i--)
				if (!tbl_used[i])
					free_slot = i;
			if (free_slot < 0) begin
				ev.status   = STATUS_FULL;
				ev.fired_id = w.task_id;
				step_q.insert(step_q.size(), ev);
			end else begin
				tbl_used[free_slot]   = 1'b1;
				tbl_id[free_slot]     = w.task_id;
				tbl_period[free_slot] = w.period_ms;
				tbl_left[free_slot]   = w.repeat_count;
				tbl_expiry[free_slot] = now_ms + TIME_W'(w.period_ms);
			end
		end
		if (step_q.size() > 0)
			step_q[step_q.size() - 1].last = 1'b1;
		foreach (step_q[i])
			expected_events.insert(expected_events.size(), step_q[i]);
	endfunction

	// Random command word: mostly a small id pool and short periods so that
	// timers fire, collide, get deleted and fill the table.
	function automatic cmd_word_t draw_timer_cmd();
		cmd_word_t w;
		int        roll;
		roll = $urandom_range(0, 99);
		if (roll < 45)
			w.kind = KIND_TICK;
		else if (roll < 70)
			w.kind = KIND_ADD;
		else if (roll < 85)
			w.kind = KIND_DELETE;
		else
			w.kind = KIND_REPLACE;
		w.task_id      = $urandom();
		w.period_ms    = $urandom();
		w.repeat_count = $urandom();
		if (w.kind != KIND_TICK) begin
			if ($urandom_range(0, 9) < 8) begin
				w.task_id = $urandom_range(0, 15);
				roll = $urandom_range(0, 99);
				if (roll < 8)
					w.period_ms = '0;
				else if (roll < 88)
					w.period_ms = $urandom_range(1, 12);
				roll = $urandom_range(0, 99);
				if (roll < 8)
					w.repeat_count = '0;
				else if (roll < 40)
					w.repeat_count = 1;
				else if (roll < 70)
					w.repeat_count = $urandom_range(2, 5);
				else if (roll < 82)
					w.repeat_count = -1;
			end else begin
				// stray id: keep it short-lived so it cannot clog the table
				w.period_ms    = $urandom_range(1, 12);
				w.repeat_count = $urandom_range(1, 3);
			end
		end
		return w;
	endfunction

	// command driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_bus.valid <= 1'b0;
			cmd_bus.data  <= '0;
			send_gap      <= 0;
			cmds_accepted <= 0;
		end else begin
			if (cmd_bus.valid && cmd_bus.ready) begin
				predict_events(cmd_bus.data);
				cmds_accepted <= cmds_accepted + 1;
			end
			if (!cmd_bus.valid || cmd_bus.ready) begin
				if (send_gap > 0) begin
					cmd_bus.valid <= 1'b0;
					send_gap      <= send_gap - 1;
				end else if (pending_cmds.size() > 0) begin
					cmd_bus.valid <= 1'b1;
					cmd_bus.data  <= pending_cmds.pop_front();
					if (!quiet_tail && $urandom_range(0, 5) == 0)
						send_gap <= $urandom_range(1, 11);
				end else
					cmd_bus.valid <= 1'b0;
			end
		end
	end

	// event monitor and sink back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_bus.ready <= 1'b0;
			stall_left    <= 0;
			hold_left     <= 0;
			pressure_done <= 1'b0;
		end else begin
			if (evt_bus.valid && evt_bus.ready) begin
				events_seen++;
				if (expected_events.size() == 0)
					flag_error($sformatf("event word %0d unexpected: status %0d id %h last %b",
						events_seen, evt_bus.data.status, evt_bus.data.fired_id,
						evt_bus.data.last));
				else begin
					want_evt = expected_events.pop_front();
					if (evt_bus.data.status !== want_evt.status)
						flag_error($sformatf("event word %0d status: got %0d want %0d",
							events_seen, evt_bus.data.status, want_evt.status));
					if (evt_bus.data.fired_id !== want_evt.fired_id)
						flag_error($sformatf("event word %0d fired_id: got %h want %h",
							events_seen, evt_bus.data.fired_id, want_evt.fired_id));
					if (evt_bus.data.last !== want_evt.last)
						flag_error($sformatf("event word %0d last: got %b want %b",
							events_seen, evt_bus.data.last, want_evt.last));
				end
			end
			// one long hold-off lets the block back up into its command input
			if (!pressure_done && cmds_accepted >= PRESSURE_AT) begin
				pressure_done <= 1'b1;
				hold_left     <= HOLD_CYCLES;
				evt_bus.ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left     <= hold_left - 1;
				evt_bus.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left    <= stall_left - 1;
				evt_bus.ready <= 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
				stall_left    <= $urandom_range(0, 10);
				evt_bus.ready <= 1'b0;
			end else
				evt_bus.ready <= 1'b1;
		end
	end

	// watchdog: cycles with no word moving on either channel
	always @(posedge clk) begin
		if (!arst_n || (cmd_bus.valid && cmd_bus.ready) || (evt_bus.valid && evt_bus.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("timeout after %0d idle cycles", idle_cycles);
		$display("testbench failed");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;

		// single shot at the top id, zero period, zero count
		push_cmd(KIND_ADD, 32'hFFFF_FFFF, 32'd1, 1);
		push_cmd(KIND_ADD, 32'd7, 32'd0, 3);
		push_cmd(KIND_ADD, 32'd8, 32'd5, 0);
		// widest period repeating forever, then a duplicate id
		push_cmd(KIND_ADD, 32'd9, 32'hFFFF_FFFF, -1);
		push_cmd(KIND_ADD, 32'd9, 32'd2, 2);
		push_cmd(KIND_TICK, 32'd0, 32'd0, 0);
		push_cmd(KIND_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, -1);
		// replace whose add part is a no-op still deletes both copies
		push_cmd(KIND_REPLACE, 32'd9, 32'd0, 1);
		// fill the table with equal expiries, extreme counts in front
		for (int i = 0; i < SLOTS; i++) begin
			if (i == 0)
				push_cmd(KIND_ADD, i, 32'd1, 32'sh8000_0000);
			else if (i == 1)
				push_cmd(KIND_ADD, i, 32'd1, 32'sh7FFF_FFFF);
			else if (i == 2)
				push_cmd(KIND_ADD, i, 32'd1, -1);
			else
				push_cmd(KIND_ADD, i, 32'd1, 1);
		end
		// add into a full table, then all slots fire on one tick
		push_cmd(KIND_ADD, 32'h8000_0001, 32'd3, 1);
		push_cmd(KIND_TICK, 32'd0, 32'd0, 0);

		for (int n = 0; n < RANDOM_ITEMS; n++)
			pending_cmds.insert(pending_cmds.size(), draw_timer_cmd());
		total_cmds = pending_cmds.size();

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		wait (cmds_accepted == total_cmds);
		wait (expected_events.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/mts_pkg.sv
rtl/core/mts_if.sv
rtl/core/multi_timer_scheduler.sv
tb/sv/testbench.sv
